>>> design/sgm_pkg.sv
// Shared types and constants for the Sobel gradient magnitude block.
package sgm_pkg;

  // Default frame limits
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  // Register field widths and reset values
  localparam int          DIM_W     = 11;
  localparam logic [10:0] DIM_RESET = 11'd1024;

  // Configuration register indexes
  localparam int          CFG_IDX_W     = 2;
  localparam logic [1:0]  CFG_IDX_WIDTH  = 2'd0;
  localparam logic [1:0]  CFG_IDX_HEIGHT = 2'd1;

  // Square root: result bits, one per step
  localparam int ROOT_W = 8;
  localparam int STEP_W = 3;

  // Result word layout
  localparam int MAG_W    = 8;
  localparam int POS_W    = 10;
  localparam int OUT_DATA_W = 32;

  // Controller to datapath commands
  typedef struct packed {
    logic              load;     // take a pixel, read the line buffers
    logic              grad;     // form Gx/Gy, update buffers and counters
    logic              mul;      // square both gradients
    logic              add;      // sum and saturate the radicand
    logic              root;     // one square root bit
    logic [STEP_W-1:0] bit_idx;  // bit tried by the root step
    logic              push;     // move the result to the output register
  } sgm_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic produce;   // current pixel completes a full window
    logic out_full;  // output register still holds a word
  } sgm_sts_t;

endpackage

>>> design/sgm_ctrl.sv
// Controller state machine sequencing one pixel through the datapath.
module sgm_ctrl
  import sgm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  sgm_sts_t sts,
  output sgm_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_GRAD,
    S_MUL,
    S_ADD,
    S_ROOT,
    S_PUSH
  } state_t;

  state_t            state_r;
  logic [STEP_W-1:0] bit_r;

  // Hold state and the root bit counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      bit_r   <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) state_r <= S_GRAD;
        end
        S_GRAD: begin
          state_r <= sts.produce ? S_MUL : S_IDLE;
        end
        S_MUL: begin
          state_r <= S_ADD;
        end
        S_ADD: begin
          bit_r   <= STEP_W'(ROOT_W - 1);
          state_r <= S_ROOT;
        end
        S_ROOT: begin
          if (bit_r == '0) state_r <= S_PUSH;
          else bit_r <= bit_r - 1'b1;
        end
        S_PUSH: begin
          if (!sts.out_full) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready = (state_r == S_IDLE);

  // Decode commands
  always_comb begin
    cmd         = '0;
    cmd.load    = (state_r == S_IDLE) && in_tvalid;
    cmd.grad    = (state_r == S_GRAD);
    cmd.mul     = (state_r == S_MUL);
    cmd.add     = (state_r == S_ADD);
    cmd.root    = (state_r == S_ROOT);
    cmd.bit_idx = bit_r;
    cmd.push    = (state_r == S_PUSH) && !sts.out_full;
  end

endmodule

>>> design/sgm_dp.sv
// Datapath: line buffers, 3x3 window, counters, gradient and square root.
module sgm_dp
  import sgm_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sgm_cmd_t              cmd,
  output sgm_sts_t              sts,
  input  logic [7:0]            in_tdata,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [DIM_W-1:0]      cfg_data,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast
);

  localparam int CW = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam logic [12:0] MaxW13 = 13'(MAX_WIDTH);
  localparam logic [12:0] MaxH13 = 13'(MAX_HEIGHT);

  // Configuration registers
  logic [DIM_W-1:0] width_r, height_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_RESET;
      height_r <= DIM_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_IDX_WIDTH)  width_r  <= cfg_data;
      if (cfg_index == CFG_IDX_HEIGHT) height_r <= cfg_data;
    end
  end

  // Clamp the registers and form the last column and row index
  logic [12:0]   w_ext, h_ext, w_last13, h_last13;
  logic [CW-1:0] w_last;
  logic [RW-1:0] h_last;
  always_comb begin
    w_ext = {2'b00, width_r};
    h_ext = {2'b00, height_r};
    if (w_ext < 13'd3)       w_last13 = 13'd2;
    else if (w_ext > MaxW13) w_last13 = MaxW13 - 13'd1;
    else                     w_last13 = w_ext - 13'd1;
    if (h_ext < 13'd3)       h_last13 = 13'd2;
    else if (h_ext > MaxH13) h_last13 = MaxH13 - 13'd1;
    else                     h_last13 = h_ext - 13'd1;
    w_last = w_last13[CW-1:0];
    h_last = h_last13[RW-1:0];
  end

  // Line buffers: upper byte two rows above, lower byte one row above
  logic [15:0]   line_mem [MAX_WIDTH];
  logic [15:0]   rd_r;
  logic [7:0]    pix_r;
  logic [CW-1:0] col_r;
  logic [RW-1:0] row_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rd_r  <= line_mem[col_r];
      pix_r <= in_tdata;
    end
    if (cmd.grad) line_mem[col_r] <= {rd_r[7:0], pix_r};
  end

  // Window columns: left (0..2) and middle (3..5), top to bottom
  logic [7:0] win_r [6];
  logic       col_end, row_end;
  assign col_end = (col_r >= w_last);
  assign row_end = (row_r >= h_last);

  // Advance window and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      for (int i = 0; i < 6; i++) win_r[i] <= '0;
    end else if (cmd.grad) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= rd_r[15:8];
      win_r[4] <= rd_r[7:0];
      win_r[5] <= pix_r;
      if (col_end) begin
        col_r <= '0;
        row_r <= row_end ? '0 : row_r + 1'b1;
      end else begin
        col_r <= col_r + 1'b1;
      end
    end
  end

  assign sts.produce = (row_r >= RW'(2)) && (col_r >= CW'(2));

  // Gradients
  logic signed [11:0] l0, l1, l2, m0, m2, q0, q1, q2, gx, gy;
  always_comb begin
    l0 = {4'd0, win_r[0]};
    l1 = {4'd0, win_r[1]};
    l2 = {4'd0, win_r[2]};
    m0 = {4'd0, win_r[3]};
    m2 = {4'd0, win_r[5]};
    q0 = {4'd0, rd_r[15:8]};
    q1 = {4'd0, rd_r[7:0]};
    q2 = {4'd0, pix_r};
    gx = (l0 - q0) + ((l1 - q1) <<< 1) + (l2 - q2);
    gy = (l0 - l2) + ((m0 - m2) <<< 1) + (q0 - q2);
  end

  logic signed [11:0] gx_r, gy_r;
  logic [MAG_W-1:0]   unused_mag;
  logic [CW-1:0]      colm2;
  logic [RW-1:0]      rowm2;
  logic [POS_W-1:0]   res_col_r, res_row_r;
  logic               res_last_r;
  assign colm2 = col_r - CW'(2);
  assign rowm2 = row_r - RW'(2);
  assign unused_mag = '0;

  // Hold gradients and position of the window
  always_ff @(posedge clk) begin
    if (cmd.grad) begin
      gx_r       <= gx;
      gy_r       <= gy;
      res_col_r  <= POS_W'(colm2);
      res_row_r  <= POS_W'(rowm2);
      res_last_r <= col_end && row_end;
    end
  end

  // Squares, sum and square root
  logic [19:0]        sqx_r, sqy_r;
  logic signed [23:0] gx_ext, gy_ext, px, py;
  logic [20:0]        sum;
  logic [15:0]        rad_r;
  logic [ROOT_W-1:0]  root_r, trial;
  logic [15:0]        trial_sq;

  // Sign-extend before squaring so the product keeps all its bits
  assign gx_ext = {{12{gx_r[11]}}, gx_r};
  assign gy_ext = {{12{gy_r[11]}}, gy_r};
  assign px  = gx_ext * gx_ext;
  assign py  = gy_ext * gy_ext;
  assign sum = {1'b0, sqx_r} + {1'b0, sqy_r};
  always_comb begin
    trial    = root_r | (ROOT_W'(1) << cmd.bit_idx);
    trial_sq = {8'd0, trial} * {8'd0, trial};
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      sqx_r <= px[19:0];
      sqy_r <= py[19:0];
    end
    if (cmd.add) begin
      rad_r  <= (sum[20:16] != '0) ? 16'hFFFF : sum[15:0];
      root_r <= unused_mag;
    end else if (cmd.root) begin
      if (trial_sq <= rad_r) root_r <= trial;
    end
  end

  // Output register
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_last_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_data_r <= {4'd0, res_col_r, res_row_r, root_r};
      out_last_r <= res_last_r;
    end
  end

  assign sts.out_full = out_valid_r;
  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tlast    = out_last_r;

endmodule

>>> design/sobel_gradient_magnitude.sv
// Top level of the Sobel 3x3 gradient magnitude block.
//
//  channel  direction  word                                          accept
//  in_      slave      tdata[7:0] pixel                              in_tvalid & in_tready
//  out_     master     tdata[7:0] magnitude, [17:8] row, [27:18] col  out_tvalid & out_tready
//                      tlast frame_done
//  cfg_     slave      index 0 image_width, 1 image_height; data      cfg_valid & cfg_ready
//
// A pixel closing a full window passes the gradient, square, sum, root and push states, a
// border pixel only the gradient state; the root unit resolves one result bit per cycle.
// The output register frees the pipeline: the next pixel is taken while a word waits.
// A new result stalls in place only while the previous word is still not taken.
// Reset clears counters, window and handshake state; line buffers are not cleared.
module sobel_gradient_magnitude
  import sgm_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,    // [7:0] pixel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,   // [7:0] magnitude, [17:8] out_row, [27:18] out_col
  output logic                  out_tlast,   // frame_done
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [DIM_W-1:0]      cfg_data
);

  sgm_cmd_t cmd;
  sgm_sts_t sts;

  assign cfg_ready = 1'b1;

  sgm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sgm_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

>>> verif/sobel_magnitude_checker.sv
// Checker for the Sobel gradient magnitude block: predicts result words and compares them.
`timescale 1ns / 100ps

module sobel_magnitude_checker
  import sgm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [7:0]            in_tdata,    // [7:0] pixel
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,   // [7:0] magnitude, [17:8] out_row, [27:18] out_col
  input  logic                  out_tlast,   // frame_done
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [DIM_W-1:0]      cfg_data,
  output int                    fail_count,
  output int                    pending,
  output int                    pos_col,
  output int                    pos_row,
  output int                    eff_width,
  output int                    eff_height
);

  localparam int LINE_DEPTH = DEF_MAX_WIDTH;
  localparam int MAX_REPORTS = 200;

  typedef struct packed {
    logic [MAG_W-1:0] magnitude;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             frame_done;
  } grad_word_t;

  // Shadow copy of the block state
  logic [7:0]       row_above     [LINE_DEPTH];
  logic [7:0]       row_two_above [LINE_DEPTH];
  logic [7:0]       win [6];
  int unsigned      col_cnt;
  int unsigned      row_cnt;
  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;

  grad_word_t magnitude_q[$];

  // Bound a raw dimension register to what the block can use
  function automatic int unsigned dim_in_use(input logic [DIM_W-1:0] raw, input int unsigned hi);
    if (raw < 3) return 3;
    if (raw > hi) return hi;
    return raw;
  endfunction

  // Integer square root, one bit at a time from the top, pinned at 255
  function automatic logic [7:0] root_sat(input int unsigned v);
    int unsigned root;
    int unsigned cand;
    if (v >= 65536) return 8'hFF;
    root = 0;
    for (int b = 7; b >= 0; b--) begin
      cand = root | (1 << b);
      if (cand * cand <= v) root = cand;
    end
    return root[7:0];
  endfunction

  // Take one pixel: queue its magnitude word if the window is full, then shift state
  task automatic predict_pixel(input logic [7:0] pix);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    int unsigned r;
    logic [7:0]  top;
    logic [7:0]  mid;
    int          gx;
    int          gy;
    int unsigned sq;
    grad_word_t  word;
    w   = dim_in_use(width_reg, DEF_MAX_WIDTH);
    h   = dim_in_use(height_reg, DEF_MAX_HEIGHT);
    c   = col_cnt;
    r   = row_cnt;
    top = 8'd0;
    mid = 8'd0;
    if (c < LINE_DEPTH) begin
      top = row_two_above[c];
      mid = row_above[c];
    end

    if (r >= 2 && c >= 2) begin
      // left column is win[0..2], middle win[3..5], right (top, mid, pix)
      gx = (int'(win[0]) - int'(top)) + 2 * (int'(win[1]) - int'(mid))
         + (int'(win[2]) - int'(pix));
      gy = (int'(win[0]) - int'(win[2])) + 2 * (int'(win[3]) - int'(win[5]))
         + (int'(top) - int'(pix));
      sq = gx * gx + gy * gy;
      word.magnitude  = root_sat(sq);
      word.row        = POS_W'(r - 2);
      word.col        = POS_W'(c - 2);
      word.frame_done = (r >= h - 1) && (c >= w - 1);
      magnitude_q.push_back(word);
    end

    // Shift line buffers and window
    if (c < LINE_DEPTH) begin
      row_two_above[c] = mid;
      row_above[c]     = pix;
    end
    win[0] = win[3];
    win[1] = win[4];
    win[2] = win[5];
    win[3] = top;
    win[4] = mid;
    win[5] = pix;

    // Advance the raster position, wrap at row and frame end
    if (c >= w - 1) begin
      col_cnt = 0;
      row_cnt = (r >= h - 1) ? 0 : r + 1;
    end else begin
      col_cnt = c + 1;
    end
  endtask

  task automatic check_field(input string field, input int unsigned want, input int unsigned got);
    if (want != got) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $error("%s mismatch: expected %0d, actual %0d", field, want, got);
    end
  endtask

  // Watch all three channels
  always @(posedge clk) begin : watch
    grad_word_t want;
    if (!rst_n) begin
      for (int i = 0; i < LINE_DEPTH; i++) begin
        row_above[i]     = 8'd0;
        row_two_above[i] = 8'd0;
      end
      for (int i = 0; i < 6; i++) win[i] = 8'd0;
      col_cnt    = 0;
      row_cnt    = 0;
      width_reg  = DIM_RESET;
      height_reg = DIM_RESET;
      magnitude_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_IDX_WIDTH: begin
            width_reg = cfg_data;
          end
          CFG_IDX_HEIGHT: begin
            height_reg = cfg_data;
          end
          default: begin
          end
        endcase
      end

      if (in_tvalid && in_tready) predict_pixel(in_tdata);

      // Compare the accepted word with the oldest prediction
      if (out_tvalid && out_tready) begin
        if (magnitude_q.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $error("unexpected result word: tdata 0x%h tlast %0b", out_tdata, out_tlast);
        end else begin
          want = magnitude_q.pop_front();
          check_field("magnitude", want.magnitude, out_tdata[7:0]);
          check_field("out_row", want.row, out_tdata[17:8]);
          check_field("out_col", want.col, out_tdata[27:18]);
          check_field("frame_done", want.frame_done, out_tlast);
        end
      end
    end

    pending    <= magnitude_q.size();
    pos_col    <= col_cnt;
    pos_row    <= row_cnt;
    eff_width  <= dim_in_use(width_reg, DEF_MAX_WIDTH);
    eff_height <= dim_in_use(height_reg, DEF_MAX_HEIGHT);
  end

endmodule

>>> verif/sobel_gradient_magnitude_tb.sv
// Testbench top for the Sobel gradient magnitude block: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module sobel_gradient_magnitude_tb;
  import sgm_pkg::*;

  localparam int CYCLE_LIMIT     = 3_000_000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int RANDOM_PIXELS   = 1000;
  localparam int SETTLE_CYCLES   = 30;
  localparam int MAX_IDLE        = 18;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic [7:0]            in_tdata   = 8'd0;
  logic                  out_tready = 1'b0;
  logic                  cfg_valid  = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [DIM_W-1:0]      cfg_data   = '0;
  logic                  in_tready;
  logic                  out_tvalid;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_ready;

  int fail_count;
  int pending;
  int pos_col;
  int pos_row;
  int eff_width;
  int eff_height;

  int cycles     = 0;
  bit snd_steady = 1'b0;
  bit rcv_steady = 1'b0;
  bit hold_req   = 1'b0;

  sobel_gradient_magnitude dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  sobel_magnitude_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending),
    .pos_col    (pos_col),
    .pos_row    (pos_row),
    .eff_width  (eff_width),
    .eff_height (eff_height)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[sobel_gradient_magnitude] ERROR");
      $finish;
    end
  end

  // Result side: random stalls, steady stretches and one long hold-off on request
  initial begin : receiver
    int stall;
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        stall = rcv_steady ? 0 : $urandom_range(0, MAX_IDLE);
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Offer one pixel word after a random gap (none when steady), hold until taken
  task automatic send_pixel(input logic [7:0] pix);
    int gap;
    gap = snd_steady ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    do @(posedge clk); while (!in_tready);
  endtask

  // Drop valid and wait until every predicted word has come out
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Drain, then let a trailing border pixel finish inside the block
  task automatic settle();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Write the chosen registers, then wait so the shadow copy can catch up
  task automatic configure(input logic [DIM_W-1:0] w_raw, input logic [DIM_W-1:0] h_raw,
                           input bit do_w, input bit do_h);
    if (do_w) write_reg(CFG_IDX_WIDTH, w_raw);
    if (do_h) write_reg(CFG_IDX_HEIGHT, h_raw);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Pixels left until the current frame wraps
  function automatic int frame_remaining();
    int row_left;
    row_left = (pos_col >= eff_width - 1) ? 1 : eff_width - pos_col;
    if (pos_row >= eff_height - 1) return row_left;
    return row_left + (eff_height - 1 - pos_row) * eff_width;
  endfunction

  // Random pixels with extra weight on black and white, occasional full drain
  task automatic send_random(input int n);
    logic [7:0] pix;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 7))
        0: begin
          pix = 8'h00;
        end
        1: begin
          pix = 8'hFF;
        end
        default: begin
          pix = 8'($urandom_range(0, 255));
        end
      endcase
      send_pixel(pix);
      if ($urandom_range(0, 199) == 0) drain_results();
    end
  endtask

  initial begin : stimulus
    logic [7:0]       directed_px [27];
    logic [DIM_W-1:0] w_raw;
    logic [DIM_W-1:0] h_raw;
    int               new_w;
    int               cap_w;
    int               n;
    int               mode;
    int               rand_sent;

    // Hard left edge (saturates), flat white (zero), one bump in the top middle
    directed_px = '{8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00,
                    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                    8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    rand_sent = 0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Smallest legal frame, directed content
    configure(11'd3, 11'd3, 1'b1, 1'b1);
    for (int i = 0; i < 27; i++) send_pixel(directed_px[i]);
    settle();

    // Fill the block: sender runs steady while the receiver holds off
    configure(11'd6, 11'd6, 1'b1, 1'b1);
    hold_req   = 1'b1;
    snd_steady = 1'b1;
    send_random(frame_remaining());
    snd_steady = 1'b0;
    settle();

    // Widest row, height below range: part of the first row only
    configure(11'd1500, 11'd1, 1'b1, 1'b1);
    send_random(40);
    settle();

    // Width below range, height at the raw maximum: wrap the long row, then 40 rows
    configure(11'd0, 11'd2047, 1'b1, 1'b1);
    send_random(121);
    settle();

    // Shrink the height in mid-frame so the current row closes the frame
    configure(11'd0, 11'd3, 1'b0, 1'b1);
    send_random(frame_remaining());
    settle();

    configure(11'd8, 11'd5, 1'b1, 1'b1);

    // Random phases with settings changed between them
    while (rand_sent < RANDOM_PIXELS) begin
      settle();
      w_raw = DIM_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 2)
                                                 : $urandom_range(3, 12));
      h_raw = DIM_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 2)
                                                 : $urandom_range(3, 8));
      // never widen in mid-frame: columns past the old width were not written this frame
      new_w = (w_raw < 3) ? 3 : int'(w_raw);
      if ((pos_col != 0 || pos_row != 0) && new_w > eff_width) begin
        cap_w = (eff_width < 12) ? eff_width : 12;
        w_raw = DIM_W'($urandom_range(3, cap_w));
      end
      configure(w_raw, h_raw, $urandom_range(0, 9) < 7, $urandom_range(0, 9) < 7);

      snd_steady = ($urandom_range(0, 3) == 0);
      rcv_steady = ($urandom_range(0, 3) == 0);
      mode = $urandom_range(0, 9);
      if (mode == 0) begin
        hold_req   = 1'b1;
        snd_steady = 1'b1;
        n = 60;
      end else if (mode <= 5) begin
        n = frame_remaining() + $urandom_range(0, 2) * eff_width * eff_height;
      end else begin
        n = $urandom_range(1, 40);
      end
      send_random(n);
      rand_sent += n;
    end

    // Wind down and give the verdict
    snd_steady = 1'b0;
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[sobel_gradient_magnitude] OK");
    end else begin
      $display("[sobel_gradient_magnitude] ERROR");
    end
    $finish;
  end

endmodule

>>> sobel_gradient_magnitude.f
design/sgm_pkg.sv
design/sgm_ctrl.sv
design/sgm_dp.sv
design/sobel_gradient_magnitude.sv
verif/sobel_magnitude_checker.sv
verif/sobel_gradient_magnitude_tb.sv
